>>> src/ksr_pkg.sv
// Package for the keyed stack with removal: request and response words,
// request and status codes, default sizes. No dependencies.
package ksr_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int KEY_BYTES_DEF = 8;
    localparam int KEY_W         = 64;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } ksr_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_depth;
        logic [5:0] entry_count;
    } ksr_rsp_t;

endpackage

>>> src/ksr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module ksr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/keyed_stack_remove.sv
// Keyed stack: push/pop go from idle to S_FIN, which loads the registered response
// once the output register is free; no new word is taken until the block is back
// in idle. Remove reads from the top one entry a cycle (up to count), then compacts
// the entries above the match one per cycle (up to count-1) and finishes in S_FIN.
// Reset clears the count and control; stack RAM contents are not cleared.
// Depends on ksr_pkg and ksr_ram.
module keyed_stack_remove #(
    parameter int DEPTH     = ksr_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = ksr_pkg::KEY_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ksr_pkg::ksr_req_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output ksr_pkg::ksr_rsp_t rsp
);
    import ksr_pkg::*;

    localparam int KW = 8 * KEY_BYTES;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [KW-1:0] key_reg, key_next;
    logic [1:0]    status_reg, status_next;
    logic [4:0]    depth_reg, depth_next;
    logic          out_valid_reg, out_valid_next;
    ksr_rsp_t      out_reg, out_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_data;

    logic          accept;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] count_x;

    ksr_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign idx_x     = XW'(idx_reg);
    assign count_x   = XW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        rd_addr        = idx_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = req.key[KW-1:0];
                    status_next = ST_OK;
                    depth_next  = '0;
                    state_next  = S_FIN;
                    unique case (req.req_type)
                        REQ_PUSH:
                        begin
                            if (count_x >= XW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = req.key[KW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                // start the walk at the top entry
                                rd_addr    = AW'(count_x - 1'b1);
                                idx_next   = AW'(count_x - 1'b1);
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (rd_data == key_reg)
                begin
                    depth_next = 5'(count_x - idx_x - 1'b1);
                    if (idx_x + 1'b1 < count_x)
                    begin
                        // fetch the entry above, write it down next cycle
                        rd_addr    = AW'(idx_x + 1'b1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_FIN;
                    end
                end
                else if (idx_reg == '0)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (idx_x + 2'd2 < count_x)
                begin
                    rd_addr  = AW'(idx_x + 2'd2);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.found_depth = depth_reg;
                    out_next.entry_count = 6'(count_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
        out_reg    <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(DEPTH))
        else $error("stack count exceeds depth");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_x + 1'b1 < count_x))
        else $error("compaction runs past the top of the stack");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (idx_x < count_x))
        else $error("search index above the top of the stack");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    a_depth_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.found_depth == 5'd0))
        else $error("found depth set on a failed request");
`endif

endmodule
